FILE: design/fcss_pkg.sv
// Package: sizes, controller states and the command word of the fixed-count subset-sum block.
`default_nettype none
package fcss_pkg;

  localparam int VALUE_BITS = 35;
  localparam int PICK_ROWS  = 15;
  localparam int SUM_WIDTH  = 320;

  localparam int SET_W     = 35;
  localparam int PICK_W    = 4;
  localparam int TARGET_W  = 9;
  localparam int IDX_W     = $clog2(VALUE_BITS);
  localparam int SHAMT_W   = $clog2(VALUE_BITS + 1);
  localparam int ROW_IDX_W = $clog2(PICK_ROWS);
  localparam int SUM_IDX_W = $clog2(SUM_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [IDX_W-1:0] idx;
    logic             finish;
  } dp_cmd_t;

endpackage
`default_nettype wire

FILE: design/fcss_dp.sv
// Datapath: item registers, the sum rows of the bitset DP and the result register.
`default_nettype none
module fcss_dp (
  input  wire logic                         clk,
  input  wire fcss_pkg::dp_cmd_t            cmd,
  input  wire logic [fcss_pkg::SET_W-1:0]    in_value_set,
  input  wire logic [fcss_pkg::PICK_W-1:0]   in_pick_count,
  input  wire logic [fcss_pkg::TARGET_W-1:0] in_target_sum,
  output logic                              out_reachable
);

  logic [fcss_pkg::VALUE_BITS-1:0] set_r;
  logic [fcss_pkg::PICK_W-1:0]     need_r;
  logic [fcss_pkg::TARGET_W-1:0]   target_r;
  logic [fcss_pkg::SUM_WIDTH-1:0]  rows_r [fcss_pkg::PICK_ROWS];
  logic [fcss_pkg::SUM_WIDTH-1:0]  rows_nxt [fcss_pkg::PICK_ROWS];
  logic                            reach_r;

  logic [fcss_pkg::SHAMT_W-1:0]   shamt;
  logic [fcss_pkg::SUM_WIDTH-1:0] sel_row;
  logic                           reach_nxt;

  // value = bit index + 1
  assign shamt = fcss_pkg::SHAMT_W'(cmd.idx) + fcss_pkg::SHAMT_W'(1);

  always_comb begin
    for (int c = 0; c < fcss_pkg::PICK_ROWS; c++) begin
      rows_nxt[c] = rows_r[c];
    end
    if (cmd.load) begin
      rows_nxt[0] = fcss_pkg::SUM_WIDTH'(1);
      for (int c = 1; c < fcss_pkg::PICK_ROWS; c++) begin
        rows_nxt[c] = '0;
      end
    end else if (cmd.step && set_r[cmd.idx]) begin
      // all rows read their old lower neighbor: same as a descending sweep
      for (int c = 1; c < fcss_pkg::PICK_ROWS; c++) begin
        rows_nxt[c] = rows_r[c] | (rows_r[c-1] << shamt);
      end
    end
  end

  always_comb begin
    sel_row   = '0;
    reach_nxt = 1'b0;
    if (32'(need_r) < fcss_pkg::PICK_ROWS) begin
      sel_row = rows_r[fcss_pkg::ROW_IDX_W'(need_r)];
    end
    if (32'(need_r) < fcss_pkg::PICK_ROWS && 32'(target_r) < fcss_pkg::SUM_WIDTH) begin
      reach_nxt = sel_row[fcss_pkg::SUM_IDX_W'(target_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r    <= fcss_pkg::VALUE_BITS'(in_value_set);
      need_r   <= in_pick_count;
      target_r <= in_target_sum;
    end
    for (int c = 0; c < fcss_pkg::PICK_ROWS; c++) begin
      rows_r[c] <= rows_nxt[c];
    end
    if (cmd.finish) begin
      reach_r <= reach_nxt;
    end
  end

  assign out_reachable = reach_r;

endmodule
`default_nettype wire

FILE: design/fcss_ctrl.sv
// Controller: sequences load, one step per value bit and the result hand-off.
`default_nettype none
module fcss_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fcss_pkg::dp_cmd_t       cmd
);

  fcss_pkg::state_t              state_r, state_nxt;
  logic [fcss_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          last_step;
  logic                          out_free;

  assign last_step = (idx_r == fcss_pkg::IDX_W'(fcss_pkg::VALUE_BITS - 1));
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      fcss_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fcss_pkg::ST_RUN;
          idx_nxt   = '0;
        end
      end
      fcss_pkg::ST_RUN: begin
        if (last_step) begin
          state_nxt = fcss_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + fcss_pkg::IDX_W'(1);
        end
      end
      fcss_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fcss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcss_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.idx    = idx_r;
    in_stall   = 1'b1;
    unique case (state_r)
      fcss_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      fcss_pkg::ST_RUN:  cmd.step = 1'b1;
      fcss_pkg::ST_DONE: cmd.finish = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcss_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result written over a pending item");

  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == fcss_pkg::ST_RUN && idx_r == '0))
    else $error("accepted item did not start at value bit 0");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcss_pkg::ST_RUN && last_step) |=> state_r == fcss_pkg::ST_DONE)
    else $error("step sweep did not end after the last value bit");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fcss_pkg::ST_RUN |-> idx_r <= fcss_pkg::IDX_W'(fcss_pkg::VALUE_BITS - 1))
    else $error("value index out of range");

endmodule
`default_nettype wire

FILE: design/fixed_count_subset_sum.sv
// Top level: fixed-count subset sum, a bitset DP over pick-count rows.
// An accepted item runs the value steps in ST_RUN, then ST_DONE registers the result and raises out_valid.
// A new item is taken only back in idle, after the sweep over value bits and the result hand-off.
// in_stall is low only while idle; a result may still wait in the output register.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out_valid.
// Sum rows are reloaded at the start of every item and need no reset.
`default_nettype none
module fixed_count_subset_sum (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fcss_pkg::SET_W-1:0]    in_value_set,
  input  wire logic [fcss_pkg::PICK_W-1:0]   in_pick_count,
  input  wire logic [fcss_pkg::TARGET_W-1:0] in_target_sum,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_reachable
);

  // command word from controller to datapath: load, step (with value index), finish
  fcss_pkg::dp_cmd_t cmd;

  fcss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Row c holds the sums reachable with exactly c picks; each step with the
  // value's bit set ORs row c-1 shifted by the value into row c for all rows.
  fcss_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_value_set  (in_value_set),
    .in_pick_count (in_pick_count),
    .in_target_sum (in_target_sum),
    .out_reachable (out_reachable)
  );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the fixed-count subset-sum block: directed corners plus random sets.
`timescale 1ns / 100ps
module testbench;

  // Generous run bound: about 1820 items fit well inside it.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Extra wait after the last answer, longer than one item's trip through the block.
  localparam int SETTLE_CYCLES = 45;
  localparam int IDLE_PCT = 29;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [fcss_pkg::SET_W-1:0]    in_value_set = '0;
  logic [fcss_pkg::PICK_W-1:0]   in_pick_count = '0;
  logic [fcss_pkg::TARGET_W-1:0] in_target_sum = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_reachable;

  // Expected answers, oldest first, pushed when the block takes an item.
  logic reachable_due[$];

  // When set, neither side idles: back-to-back traffic.
  bit steady = 1'b0;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reachable_hits = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  fixed_count_subset_sum dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value_set  (in_value_set),
    .in_pick_count (in_pick_count),
    .in_target_sum (in_target_sum),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_reachable (out_reachable)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding",
               cycle_count, reachable_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Bitset DP: one row of reachable sums per pick count. Each available value,
  // smallest first, shifts row c-1 into row c, top row down, so a value is used
  // at most once. Shifted-out sums above the row width are lost.
  function automatic logic predict_reachable(input logic [fcss_pkg::SET_W-1:0] values,
                                             input logic [fcss_pkg::PICK_W-1:0] picks,
                                             input logic [fcss_pkg::TARGET_W-1:0] goal);
    logic [fcss_pkg::SUM_WIDTH-1:0] sums [fcss_pkg::PICK_ROWS];
    // No row for that many picks, or a goal past the row width: never reachable.
    if (picks >= fcss_pkg::PICK_ROWS || goal >= fcss_pkg::SUM_WIDTH) return 1'b0;
    foreach (sums[r]) sums[r] = '0;
    sums[0][0] = 1'b1;  // the empty choice
    for (int v = 0; v < fcss_pkg::VALUE_BITS; v++) begin
      if (values[v]) begin
        for (int c = picks; c > 0; c--) sums[c] |= sums[c-1] << (v + 1);
      end
    end
    return sums[picks][goal];
  endfunction

  // Result side: random stall, and every taken result is checked against the
  // oldest expectation.
  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen <= results_seen + 1;
      if (reachable_due.size() == 0) begin
        $error("reachable: result %0b arrived with no item outstanding", out_reachable);
        fault_count <= fault_count + 1;
      end else begin
        if (out_reachable !== reachable_due[0]) begin
          $error("reachable mismatch: expected %0b, actual %0b",
                 reachable_due[0], out_reachable);
          fault_count <= fault_count + 1;
        end
        if (reachable_due[0]) reachable_hits <= reachable_hits + 1;
        void'(reachable_due.pop_front());
      end
    end
  end

  // Offer one item; hold it steady until the block takes it. Valid stays high on
  // return so back-to-back items never drop it within a step.
  task automatic send_item(input logic [fcss_pkg::SET_W-1:0] values,
                           input logic [fcss_pkg::PICK_W-1:0] picks,
                           input logic [fcss_pkg::TARGET_W-1:0] goal);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_set  <= values;
    in_pick_count <= picks;
    in_target_sum <= goal;
    do @(posedge clk); while (in_stall !== 1'b0);
    reachable_due.push_back(predict_reachable(values, picks, goal));
    items_sent++;
  endtask

  // Sender holds off until every outstanding answer has been collected.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (reachable_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [fcss_pkg::SET_W-1:0] random_set();
    return fcss_pkg::SET_W'({$urandom(), $urandom()});
  endfunction

  // Corners: empty set, full set, zero picks, top value alone, smallest and
  // largest reachable sums, the row-width edge, and a pick count with no row.
  task automatic test_corners();
    logic [fcss_pkg::SET_W-1:0] full;
    full = '1;
    send_item('0, 4'd0, 9'd0);
    send_item('0, 4'd0, 9'd1);
    send_item(full, 4'd0, 9'd0);
    send_item(full, 4'd0, 9'd511);
    send_item('0, 4'd1, 9'd0);
    send_item(full, 4'd1, 9'd35);
    send_item(fcss_pkg::SET_W'(1) << 34, 4'd1, 9'd35);
    send_item(fcss_pkg::SET_W'(1) << 34, 4'd1, 9'd34);
    send_item(fcss_pkg::SET_W'(1), 4'd1, 9'd1);
    send_item(fcss_pkg::SET_W'(5), 4'd2, 9'd4);
    send_item(full, 4'd2, 9'd69);
    send_item(full, 4'd2, 9'd70);
    send_item(full, 4'd14, 9'd105);
    send_item(full, 4'd14, 9'd104);
    send_item(full, 4'd14, 9'd319);
    send_item(full, 4'd14, 9'd320);
    send_item(full, 4'd13, 9'd511);
    send_item(full, 4'd15, 9'd120);
    send_item(full, 4'd15, 9'd0);
    send_item(fcss_pkg::SET_W'(35'h2AAAAAAAA), 4'd3, 9'd60);
    send_item(fcss_pkg::SET_W'(35'h555555555), 4'd7, 9'd49);
    drain_answers();
  endtask

  // Every field uniform over its full width.
  task automatic test_uniform(input int count);
    repeat (count)
      send_item(random_set(), fcss_pkg::PICK_W'($urandom()),
                fcss_pkg::TARGET_W'($urandom()));
  endtask

  // Mostly answerable queries: pick k distinct values, aim at their sum, and
  // hide them in a random superset. Some targets are nudged off by one or
  // replaced, and some pick counts are skewed, to hit near misses.
  task automatic test_planted(input int count);
    logic [fcss_pkg::SET_W-1:0] chosen;
    int k, total, v, roll;
    logic [fcss_pkg::PICK_W-1:0] picks;
    logic [fcss_pkg::TARGET_W-1:0] goal;
    repeat (count) begin
      k = $urandom_range(1, fcss_pkg::PICK_ROWS - 1);
      chosen = '0;
      total = 0;
      for (int n = 0; n < k; n++) begin
        do v = $urandom_range(0, fcss_pkg::VALUE_BITS - 1); while (chosen[v]);
        chosen[v] = 1'b1;
        total += v + 1;
      end
      picks = fcss_pkg::PICK_W'(k);
      goal = fcss_pkg::TARGET_W'(total);
      roll = $urandom_range(99);
      if (roll < 10) goal = goal + 1;
      else if (roll < 20) goal = goal - 1;
      else if (roll < 25) goal = fcss_pkg::TARGET_W'($urandom());
      else if (roll < 30) picks = fcss_pkg::PICK_W'(k + ($urandom_range(1) ? 1 : -1));
      if ($urandom_range(3) == 0) chosen |= random_set() & random_set();
      else if ($urandom_range(1)) chosen |= random_set();
      send_item(chosen, picks, goal);
    end
  endtask

  // Few values available: most answers are no, small pick counts dominate.
  task automatic test_sparse(input int count);
    repeat (count)
      send_item(random_set() & random_set() & random_set(),
                fcss_pkg::PICK_W'($urandom_range(0, 5)),
                fcss_pkg::TARGET_W'($urandom_range(0, 140)));
  endtask

  // A long stretch with no idling on either side.
  task automatic test_back_to_back(input int count);
    steady = 1'b1;
    test_planted(count);
    steady = 1'b0;
  endtask

  initial begin
    // Synchronous reset held low from the start, then released.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_uniform(350);
    test_planted(700);
    drain_answers();
    test_sparse(300);
    test_back_to_back(250);
    test_uniform(200);

    // Wind down: all items are in; collect the remaining answers.
    in_valid <= 1'b0;
    while (reachable_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items over corners, uniform, planted, sparse and back-to-back traffic;",
             items_sent);
    $display("checked %0d answers, %0d of them reachable, %0d mismatches.",
             results_seen, reachable_hits, fault_count);
    if (fault_count == 0 && reachable_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
